// ----- rtl/rsg_pkg.sv -----
// ----------------------------------------------------------------------------
// RGBA Sobel gradient package
// Shared types and constants for the RGBA Sobel gradient stream.
// ----------------------------------------------------------------------------
package rsg_pkg;

  typedef logic [31:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_t;

  typedef logic signed [10:0] grad_t;

  localparam int unsigned GradW  = 8;
  localparam int unsigned GradMax = 255;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 13;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = CfgIdxW'(1);

  localparam int unsigned WidthReset  = 640;
  localparam int unsigned HeightReset = 480;

  // Bit positions of the result kinds released by one pixel, in emission order.
  localparam int unsigned NumKinds   = 4;
  localparam int unsigned KindMid    = 0;
  localparam int unsigned KindRight  = 1;
  localparam int unsigned KindBottom = 2;
  localparam int unsigned KindCorner = 3;

endpackage

// ----- rtl/rsg_line_store.sv -----
// ----------------------------------------------------------------------------
// RGBA Sobel line store
// Holds the two previous rows of the frame, one packed word pair per column.
// ----------------------------------------------------------------------------
module rsg_line_store
  import rsg_pkg::*;
#(
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output line_t                    rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  line_t                    wr_data_i
);

  line_t mem [Depth];
  line_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/rsg_col_cell.sv -----
// ----------------------------------------------------------------------------
// RGBA Sobel window column cell
// One column of the 3x3 window; takes its shift input column on every shift.
// ----------------------------------------------------------------------------
module rsg_col_cell
  import rsg_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  logic load_i,
  input  col_t new_col_i,
  input  col_t shift_col_i,
  output col_t col_o
);

  col_t col_q;
  col_t col_d;

  always_comb begin
    col_d = col_q;
    if (en_i) begin
      col_d = load_i ? new_col_i : shift_col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign col_o = col_q;

endmodule

// ----- rtl/rsg_sobel.sv -----
// ----------------------------------------------------------------------------
// RGBA Sobel kernel
// Two-stage 3x3 Sobel on four channels with L1 magnitude and channel maximum.
// ----------------------------------------------------------------------------
module rsg_sobel
  import rsg_pkg::*;
(
  input  logic             clk_i,
  input  logic             a_en_i,
  input  logic             b_en_i,
  input  col_t [2:0]       win_i,
  input  logic             col_end_i,
  input  logic             row_end_i,
  output logic [GradW-1:0] grad_o
);

  localparam logic [1:0] RowTop = 2'd0;
  localparam logic [1:0] RowMid = 2'd1;

  function automatic pix_t row_of(col_t c, logic [1:0] s);
    pix_t v;
    case (s)
      RowTop:  v = c.top;
      RowMid:  v = c.mid;
      default: v = c.bot;
    endcase
    return v;
  endfunction

  grad_t [3:0] gx_d, gy_d, gx_q, gy_q;
  logic [GradW-1:0] grad_d, grad_q;

  always_comb begin
    pix_t       p [3][3];
    logic [1:0] ci;
    logic [1:0] rj;
    logic [7:0] t [3][3];
    logic [9:0] xp, xn, yp, yn;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        ci = col_end_i ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
        rj = row_end_i ? ((j == 0) ? 2'd1 : 2'd2) : 2'(j);
        p[j][i] = row_of(win_i[ci], rj);
      end
    end
    for (int ch = 0; ch < 4; ch++) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          t[j][i] = p[j][i][8*ch +: 8];
        end
      end
      xp = {2'b0, t[0][2]} + {1'b0, t[1][2], 1'b0} + {2'b0, t[2][2]};
      xn = {2'b0, t[0][0]} + {1'b0, t[1][0], 1'b0} + {2'b0, t[2][0]};
      yp = {2'b0, t[2][0]} + {1'b0, t[2][1], 1'b0} + {2'b0, t[2][2]};
      yn = {2'b0, t[0][0]} + {1'b0, t[0][1], 1'b0} + {2'b0, t[0][2]};
      gx_d[ch] = $signed({1'b0, xp}) - $signed({1'b0, xn});
      gy_d[ch] = $signed({1'b0, yp}) - $signed({1'b0, yn});
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en_i) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  always_comb begin
    logic [9:0]  ax, ay;
    logic [10:0] mag, best;
    logic [8:0]  quo;
    best = '0;
    for (int ch = 0; ch < 4; ch++) begin
      ax  = gx_q[ch][10] ? 10'(-gx_q[ch]) : gx_q[ch][9:0];
      ay  = gy_q[ch][10] ? 10'(-gy_q[ch]) : gy_q[ch][9:0];
      mag = {1'b0, ax} + {1'b0, ay};
      if (mag > best) begin
        best = mag;
      end
    end
    quo    = best[10:2];
    grad_d = (32'(quo) > GradMax) ? GradW'(GradMax) : quo[GradW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (b_en_i) begin
      grad_q <= grad_d;
    end
  end

  assign grad_o = grad_q;

endmodule

// ----- rtl/rgba_sobel_gradient_stream.sv -----
// ----------------------------------------------------------------------------
// RGBA Sobel gradient stream
// Per-pixel max-channel L1 Sobel gradient of a raster-order RGBA frame.
// ----------------------------------------------------------------------------
// Pixels enter on the slave stream, one per transfer, in raster order. Each
// result on the master stream carries the gradient and the center coordinates
// in tdata, the bottom-right flag of the frame in tuser, and in tlast a mark
// on the last result that one input pixel releases.
// The block takes one pixel per cycle while each pixel releases at most one
// result and the receiver is ready. A pixel at the end of a row below the
// first, or a pixel of the last row past its first column, releases two
// results, and the last pixel of the frame releases four. They leave one per
// cycle, while the receiver is ready, through the single Sobel unit, and the
// input waits while the rest issue.
// Frame size is written on the configuration channel, which is always ready;
// any write to a known register restarts the frame at its first pixel.
// After reset the size is 640 by 480 and the next pixel starts a frame; the
// line store needs no clearing. When the receiver stalls, the stages fill up
// and the slave tready drops until results drain.
// ----------------------------------------------------------------------------
module rgba_sobel_gradient_stream
  import rsg_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned ColW     = $clog2(MAX_WIDTH),
  localparam int unsigned RowW     = $clog2(MAX_HEIGHT),
  localparam int unsigned OutW     = GradW + ColW + RowW,
  localparam int unsigned OutDataW = ((OutW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Fields from bit 0: red, green, blue, alpha.
  input  logic [31:0]         s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: gradient, out_col, out_row, zero fill.
  output logic [OutDataW-1:0] m_axis_tdata,
  // Field: frame_done.
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned WLastRst =
    ((WidthReset > MAX_WIDTH) ? MAX_WIDTH : WidthReset) - 1;
  localparam int unsigned HLastRst =
    ((HeightReset > MAX_HEIGHT) ? MAX_HEIGHT : HeightReset) - 1;

  logic cfg_fire, in_fire;

  logic [ColW-1:0] wlast_q, wlast_d;
  logic [RowW-1:0] hlast_q, hlast_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic                s1_valid_q, s1_valid_d;
  pix_t                s1_pix_q;
  logic [ColW-1:0]     s1_col_q;
  logic [RowW-1:0]     s1_row_q;
  logic                s1_first_row_q, s1_first_col_q;
  logic [NumKinds-1:0] s1_mask_q, mask_in;
  logic                s1_adv;

  logic                e_valid_q, e_valid_d;
  logic [NumKinds-1:0] e_mask_q, e_mask_d;
  logic [ColW-1:0]     e_col_q;
  logic [RowW-1:0]     e_row_q;
  logic [NumKinds-1:0] e_low, e_rest;
  logic                e_issue, e_finish, k_col_end, k_row_end;

  logic            a_valid_q, a_valid_d;
  logic [ColW-1:0] a_col_q;
  logic [RowW-1:0] a_row_q;
  logic            a_done_q, a_last_q;

  logic            o_valid_q, o_valid_d;
  logic [ColW-1:0] o_col_q;
  logic [RowW-1:0] o_row_q;
  logic            o_done_q, o_last_q;
  logic [GradW-1:0] grad;

  logic a_ready, o_ready, b_en;

  line_t      rd_line, wr_line;
  pix_t       top_px, mid_px;
  col_t       new_col;
  col_t [2:0] win;

  // Configuration.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_comb begin
    logic [31:0] v;
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    v = '0;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        CfgFrameWidth: begin
          v = 32'(cfg_data_i[CfgWidthW-1:0]);
          if (v < 32'd2) begin
            v = 32'd2;
          end else if (v > MAX_WIDTH) begin
            v = MAX_WIDTH;
          end
          wlast_d = ColW'(v - 32'd1);
        end
        CfgFrameHeight: begin
          v = 32'(cfg_data_i[CfgHeightW-1:0]);
          if (v < 32'd2) begin
            v = 32'd2;
          end else if (v > MAX_HEIGHT) begin
            v = MAX_HEIGHT;
          end
          hlast_d = RowW'(v - 32'd1);
        end
        default: begin
        end
      endcase
    end
  end

  // Input position and release mask.
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~s1_valid_q | s1_adv;

  always_comb begin
    logic lc, lr, c1, r1;
    lc = (col_q == wlast_q);
    lr = (row_q == hlast_q);
    c1 = (col_q != '0);
    r1 = (row_q != '0);
    mask_in             = '0;
    mask_in[KindMid]    = c1 & r1;
    mask_in[KindRight]  = c1 & r1 & lc;
    mask_in[KindBottom] = c1 & lr;
    mask_in[KindCorner] = c1 & lr & lc;

    col_d = col_q;
    row_d = row_q;
    if (cfg_fire && (cfg_index_i == CfgFrameWidth || cfg_index_i == CfgFrameHeight)) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (lc) begin
        col_d = '0;
        row_d = lr ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // Line store: read at transfer, write back when the pixel leaves stage one.
  assign top_px          = s1_first_row_q ? s1_pix_q : rd_line.older;
  assign mid_px          = s1_first_row_q ? s1_pix_q : rd_line.newer;
  assign wr_line.older   = mid_px;
  assign wr_line.newer   = s1_pix_q;
  assign new_col.top     = top_px;
  assign new_col.mid     = mid_px;
  assign new_col.bot     = s1_pix_q;

  rsg_line_store #(
    .Depth(MAX_WIDTH)
  ) u_line_store (
    .clk_i    (clk_i),
    .rd_en_i  (in_fire),
    .rd_addr_i(col_q),
    .rd_data_o(rd_line),
    .wr_en_i  (s1_adv),
    .wr_addr_i(s1_col_q),
    .wr_data_i(wr_line)
  );

  for (genvar k = 0; k < 3; k++) begin : g_cell
    if (k == 2) begin : g_head
      rsg_col_cell u_cell (
        .clk_i      (clk_i),
        .en_i       (s1_adv),
        .load_i     (s1_first_col_q),
        .new_col_i  (new_col),
        .shift_col_i(new_col),
        .col_o      (win[k])
      );
    end else begin : g_body
      rsg_col_cell u_cell (
        .clk_i      (clk_i),
        .en_i       (s1_adv),
        .load_i     (s1_first_col_q),
        .new_col_i  (new_col),
        .shift_col_i(win[k+1]),
        .col_o      (win[k])
      );
    end
  end

  // Emission sequencing: one result kind per cycle while stage A is ready, lowest first.
  assign e_low     = e_mask_q & (~e_mask_q + 1'b1);
  assign e_rest    = e_mask_q & ~e_low;
  assign e_issue   = e_valid_q & a_ready;
  assign e_finish  = e_issue & (e_rest == '0);
  assign s1_adv    = s1_valid_q & (~e_valid_q | e_finish);
  assign k_col_end = e_low[KindRight] | e_low[KindCorner];
  assign k_row_end = e_low[KindBottom] | e_low[KindCorner];

  assign o_ready = ~o_valid_q | m_axis_tready;
  assign a_ready = ~a_valid_q | o_ready;
  assign b_en    = a_valid_q & o_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    e_valid_d = e_valid_q;
    e_mask_d  = e_mask_q;
    if (s1_adv) begin
      e_valid_d = |s1_mask_q;
      e_mask_d  = s1_mask_q;
    end else if (e_issue) begin
      e_valid_d = |e_rest;
      e_mask_d  = e_rest;
    end

    a_valid_d = a_valid_q;
    if (e_issue) begin
      a_valid_d = 1'b1;
    end else if (o_ready) begin
      a_valid_d = 1'b0;
    end

    o_valid_d = o_valid_q;
    if (b_en) begin
      o_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q    <= ColW'(WLastRst);
      hlast_q    <= RowW'(HLastRst);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      e_valid_q  <= 1'b0;
      e_mask_q   <= '0;
      a_valid_q  <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      wlast_q    <= wlast_d;
      hlast_q    <= hlast_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      e_valid_q  <= e_valid_d;
      e_mask_q   <= e_mask_d;
      a_valid_q  <= a_valid_d;
      o_valid_q  <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q       <= s_axis_tdata;
      s1_col_q       <= col_q;
      s1_row_q       <= row_q;
      s1_first_row_q <= (row_q == '0);
      s1_first_col_q <= (col_q == '0);
      s1_mask_q      <= mask_in;
    end
    if (s1_adv) begin
      e_col_q <= s1_col_q;
      e_row_q <= s1_row_q;
    end
    if (e_issue) begin
      a_col_q  <= k_col_end ? e_col_q : e_col_q - 1'b1;
      a_row_q  <= k_row_end ? e_row_q : e_row_q - 1'b1;
      a_done_q <= e_low[KindCorner];
      a_last_q <= (e_rest == '0);
    end
    if (b_en) begin
      o_col_q  <= a_col_q;
      o_row_q  <= a_row_q;
      o_done_q <= a_done_q;
      o_last_q <= a_last_q;
    end
  end

  rsg_sobel u_sobel (
    .clk_i    (clk_i),
    .a_en_i   (e_issue),
    .b_en_i   (b_en),
    .win_i    (win),
    .col_end_i(k_col_end),
    .row_end_i(k_row_end),
    .grad_o   (grad)
  );

  assign m_axis_tdata  = OutDataW'({o_row_q, o_col_q, grad});
  assign m_axis_tuser  = o_done_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tvalid = o_valid_q;

endmodule

// ----- tb/sv/rgba_sobel_gradient_stream_test.sv -----
// ----------------------------------------------------------------------------
// RGBA Sobel gradient stream test
// Streams RGBA frames of many sizes through the block and checks every
// gradient, coordinate, frame-done flag and last-of-pixel mark against a
// raster predictor kept in step with each pixel transfer.
// ----------------------------------------------------------------------------
module rgba_sobel_gradient_stream_test
  import rsg_pkg::*;
();

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned ColW        = $clog2(MaxWidth);
  localparam int unsigned RowW        = $clog2(MaxHeight);
  localparam int unsigned ResultDataW = ((GradW + ColW + RowW + 7) / 8) * 8;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned EndCycles   = 20;
  localparam int unsigned ResetItems  = 48;
  localparam int unsigned ClampItems  = 32;
  localparam int unsigned RandomItems = 250;
  localparam int unsigned CycleLimit  = 500000;

  localparam logic [CfgIdxW-1:0] CfgSpareLow  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = CfgIdxW'(3);

  typedef struct {
    logic [GradW-1:0] gradient;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic             frame_done;
    logic             run_last;
  } gradient_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [31:0]            s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ResultDataW-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i = '0;
  logic [CfgDataW-1:0]    cfg_data_i = '0;

  gradient_result_t pending_gradients[$];
  int unsigned      error_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      feed_calm = 0;
  int unsigned      drain_calm = 0;
  int unsigned      stall_left = 0;

  logic [CfgWidthW-1:0]  width_reg = CfgWidthW'(WidthReset);
  logic [CfgHeightW-1:0] height_reg = CfgHeightW'(HeightReset);
  logic [31:0]           older_row [MaxWidth];
  logic [31:0]           newer_row [MaxWidth];
  logic [31:0]           window [9];
  int unsigned           next_col = 0;
  int unsigned           next_row = 0;

  rgba_sobel_gradient_stream #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 40) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // The shifts move kernel columns or rows onto the newest window column or
  // row, which replicates the right or bottom border.
  function automatic logic [GradW-1:0] max_channel_gradient(input int unsigned col_shift,
                                                            input int unsigned row_shift);
    logic [31:0] p [3][3];
    int          a [3][3];
    int          gx, gy, mag, best, ci, ri;
    best = 0;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        ci = (i + col_shift > 2) ? 2 : i + col_shift;
        ri = (j + row_shift > 2) ? 2 : j + row_shift;
        p[j][i] = window[ci * 3 + ri];
      end
    end
    for (int ch = 0; ch < 4; ch++) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          a[j][i] = p[j][i][8 * ch +: 8];
        end
      end
      gx = (a[0][2] + 2 * a[1][2] + a[2][2]) - (a[0][0] + 2 * a[1][0] + a[2][0]);
      gy = (a[2][0] + 2 * a[2][1] + a[2][2]) - (a[0][0] + 2 * a[0][1] + a[0][2]);
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > best) best = mag;
    end
    best = best / 4;
    return (best > GradMax) ? GradW'(GradMax) : GradW'(best);
  endfunction

  function automatic gradient_result_t center_result(input int unsigned col_shift,
                                                     input int unsigned row_shift,
                                                     input int unsigned col,
                                                     input int unsigned row,
                                                     input logic done);
    gradient_result_t res;
    res.gradient   = max_channel_gradient(col_shift, row_shift);
    res.col        = ColW'(col);
    res.row        = RowW'(row);
    res.frame_done = done;
    res.run_last   = 1'b0;
    return res;
  endfunction

  function automatic void advance_raster(input logic [31:0] pixel);
    int unsigned      w, h, c, r;
    logic [31:0]      top, mid;
    logic             last_col, last_row;
    gradient_result_t released[$];
    w = clamp_size(width_reg, MaxWidth);
    h = clamp_size(height_reg, MaxHeight);
    c = (next_col > w - 1) ? w - 1 : next_col;
    r = (next_row > h - 1) ? h - 1 : next_row;
    last_col = (c == w - 1);
    last_row = (r == h - 1);
    if (r == 0) begin
      top = pixel;
      mid = pixel;
    end else begin
      top = older_row[c];
      mid = newer_row[c];
    end
    older_row[c] = mid;
    newer_row[c] = pixel;
    if (c == 0) begin
      for (int k = 0; k < 3; k++) begin
        window[k * 3]     = top;
        window[k * 3 + 1] = mid;
        window[k * 3 + 2] = pixel;
      end
    end else begin
      for (int k = 0; k < 6; k++) window[k] = window[k + 3];
      window[6] = top;
      window[7] = mid;
      window[8] = pixel;
    end
    if (c >= 1 && r >= 1) begin
      released.insert(released.size(), center_result(0, 0, c - 1, r - 1, 1'b0));
      if (last_col) released.insert(released.size(), center_result(1, 0, c, r - 1, 1'b0));
    end
    if (c >= 1 && last_row) begin
      released.insert(released.size(), center_result(0, 1, c - 1, r, 1'b0));
      if (last_col) released.insert(released.size(), center_result(1, 1, c, r, 1'b1));
    end
    if (released.size() > 0) released[released.size() - 1].run_last = 1'b1;
    foreach (released[k]) pending_gradients.insert(pending_gradients.size(), released[k]);
    if (last_col) begin
      next_col = 0;
      next_row = last_row ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (feed_calm > 0) begin
      feed_calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      feed_calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin : drain_ctrl
    int unsigned roll;
    if (drain_calm > 0) begin
      drain_calm <= drain_calm - 1;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        drain_calm <= $urandom_range(30, 120);
        m_axis_tready <= 1'b1;
      end else if (roll < 70) begin
        m_axis_tready <= 1'b1;
      end else if (roll < 95) begin
        stall_left <= $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        stall_left <= $urandom_range(8, 30);
        m_axis_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    gradient_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_gradients.size() == 0) begin
        report_mismatch($sformatf("result transfer with nothing expected, tdata %h",
                                  m_axis_tdata));
      end else begin
        exp_res = pending_gradients.pop_front();
        if (m_axis_tdata[GradW-1:0] !== exp_res.gradient)
          report_mismatch($sformatf("gradient %h, expected %h at col %0d row %0d",
                                    m_axis_tdata[GradW-1:0], exp_res.gradient,
                                    exp_res.col, exp_res.row));
        if (m_axis_tdata[GradW+ColW-1:GradW] !== exp_res.col)
          report_mismatch($sformatf("out_col %h, expected %h",
                                    m_axis_tdata[GradW+ColW-1:GradW], exp_res.col));
        if (m_axis_tdata[GradW+ColW+RowW-1:GradW+ColW] !== exp_res.row)
          report_mismatch($sformatf("out_row %h, expected %h",
                                    m_axis_tdata[GradW+ColW+RowW-1:GradW+ColW],
                                    exp_res.row));
        if (m_axis_tuser !== exp_res.frame_done)
          report_mismatch($sformatf("frame_done %b, expected %b at col %0d row %0d",
                                    m_axis_tuser, exp_res.frame_done,
                                    exp_res.col, exp_res.row));
        if (m_axis_tlast !== exp_res.run_last)
          report_mismatch($sformatf("run_last %b, expected %b at col %0d row %0d",
                                    m_axis_tlast, exp_res.run_last,
                                    exp_res.col, exp_res.row));
      end
    end
  end

  task automatic send_pixel(input logic [31:0] pixel);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= pixel;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_raster(pixel);
  endtask

  task automatic send_random_pixels(input int unsigned count);
    repeat (count) send_pixel($urandom());
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_gradients.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [CfgDataW-1:0] value);
    wait_idle();
    cfg_index_i <= index;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == CfgFrameWidth) begin
      width_reg = value[CfgWidthW-1:0];
    end else if (index == CfgFrameHeight) begin
      height_reg = value[CfgHeightW-1:0];
    end else begin
      return;
    end
    next_col = 0;
    next_row = 0;
  endtask

  task automatic set_frame_size(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    write_register(CfgFrameWidth, w);
    write_register(CfgFrameHeight, h);
  endtask

  // The first pixels of the first row at the reset width of 640 release nothing.
  task automatic test_reset_size();
    send_random_pixels(ResetItems);
  endtask

  task automatic test_small_frames();
    set_frame_size(2, 2);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h00FF_00FF);
    send_pixel(32'hFF00_FF00);
    // A diagonal step edge drives the magnitude well past saturation.
    set_frame_size(3, 3);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send_pixel({8'(c * 40 + r * 90), (c + r >= 2) ? 24'hFF_FFFF : 24'h00_0000});
      end
    end
  endtask

  task automatic test_restart_and_spare_index();
    set_frame_size(3, 2);
    send_random_pixels(2);
    write_register(CfgSpareLow, 16'hFFFF);
    send_random_pixels(2);
    write_register(CfgSpareHigh, 16'h0000);
    write_register(CfgFrameHeight, 2);
    send_random_pixels(6);
  endtask

  task automatic test_size_clamps();
    set_frame_size(0, 1);
    send_random_pixels(8);
    set_frame_size(1, 0);
    send_random_pixels(4);
    set_frame_size(16'hFFFF, 2);
    send_random_pixels(ClampItems);
    set_frame_size(2, 16'hFFFF);
    send_random_pixels(ClampItems);
  endtask

  task automatic test_random_frames();
    int unsigned sent, pick, w, h, count;
    logic [CfgDataW-1:0] w_val, h_val;
    sent = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if (pick < 70) begin
          w_val = CfgDataW'($urandom_range(2, 9));
          h_val = CfgDataW'($urandom_range(2, 7));
        end else begin
          w_val = CfgDataW'($urandom_range(0, 1));
          h_val = CfgDataW'($urandom_range(0, 5));
        end
        set_frame_size(w_val, h_val);
        w = clamp_size(w_val[CfgWidthW-1:0], MaxWidth);
        h = clamp_size(h_val[CfgHeightW-1:0], MaxHeight);
        if ($urandom_range(0, 9) == 0) begin
          count = $urandom_range(1, w * h - 1);
        end else begin
          count = w * h * $urandom_range(1, 2);
        end
      end else if (pick < 90) begin
        write_register($urandom_range(0, 1) ? CfgSpareLow : CfgSpareHigh,
                       CfgDataW'($urandom()));
        count = $urandom_range(1, 20);
      end else begin
        set_frame_size(CfgDataW'($urandom()), CfgDataW'($urandom()));
        count = $urandom_range(1, 40);
      end
      send_random_pixels(count);
      sent += count;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_small_frames();
    test_restart_and_spare_index();
    test_size_clamps();
    test_random_frames();
    s_axis_tvalid <= 1'b0;
    while (pending_gradients.size() != 0) @(posedge clk_i);
    repeat (EndCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- rgba_sobel_gradient_stream.f -----
rtl/rsg_pkg.sv
rtl/rsg_line_store.sv
rtl/rsg_col_cell.sv
rtl/rsg_sobel.sv
rtl/rgba_sobel_gradient_stream.sv
tb/sv/rgba_sobel_gradient_stream_test.sv
